@@ design/f32_pkg.sv @@
// ----------------------------------------------------------------------------
// f32_pkg
// Shared types, constants and the end-around-carry add for the Fletcher-32
// byte checksum block.
// ----------------------------------------------------------------------------
package f32_pkg;

    localparam int unsigned SUM_W    = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CSUM_W   = 2 * SUM_W;

    // both running sums start here, and zero mod 65535 is held as this value
    localparam logic [SUM_W-1:0] SUM_INIT = {SUM_W{1'b1}};

    // result handed from the accumulator to the output buffer
    typedef struct packed {
        logic              valid;
        logic [CSUM_W-1:0] checksum;
    } t_result;

    // one's complement add, modulo 65535 by end-around carry
    function automatic logic [SUM_W-1:0] fold_add(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b
    );
        logic [SUM_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            fold_add = s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
        end
    endfunction

endpackage

@@ design/f32_if.sv @@
// ----------------------------------------------------------------------------
// f32_if
// Valid/ready channels of the checksum block: byte input and checksum output.
// ----------------------------------------------------------------------------
interface f32_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface f32_sum_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum;

    modport source (output valid, output checksum, input ready);
    modport sink   (input valid, input checksum, output ready);
endinterface

@@ design/fletcher32_byte_checksum.sv @@
// ----------------------------------------------------------------------------
// fletcher32_byte_checksum
// Fletcher-32 over a byte stream: bytes pair into little-endian words, two
// sums mod 65535, checksum {second, first} out at the byte marked last.
//
//   channel   dir   transfer moves                  per message
//   i_byte    in    data_byte[7:0], last_byte       one per byte
//   o_sum     out   checksum[31:0]                  one, at last byte
//
// A byte passes from input transfer to checksum output through the input
// register and the result register, with the sum update between. One byte
// is accepted every cycle unless a last byte waits on the full result
// register; the input register and two folded 16-bit adds set the rate.
// A stalled output holds the result register; the input keeps streaming
// until a second last byte meets the full result register.
// Synchronous active-low reset sets both sums to 0xffff, low byte expected.
// ----------------------------------------------------------------------------
module fletcher32_byte_checksum (
    input  logic      i_clk,
    input  logic      i_rst_n,
    f32_byte_if.sink  i_byte,
    f32_sum_if.source o_sum
);
    import f32_pkg::*;

    t_result res;
    logic    res_ready;

    // running sums
    f32_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // result register
    f32_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_sum       (o_sum)
    );

endmodule

@@ design/f32_accum.sv @@
// ----------------------------------------------------------------------------
// f32_accum
// Input register and the running-sum update: one byte per cycle unless a
// last byte stalls, two folded adds, checksum handed on at the last byte.
// ----------------------------------------------------------------------------
module f32_accum (
    input  logic             i_clk,
    input  logic             i_rst_n,
    f32_byte_if.sink         i_byte,
    output f32_pkg::t_result o_res,
    input  logic             i_res_ready
);
    import f32_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic [SUM_W-1:0]  r_first;
    logic [SUM_W-1:0]  r_second;
    logic              r_high_next;

    logic [SUM_W-1:0]  n_first;
    logic [SUM_W-1:0]  n_second;
    logic [SUM_W-1:0]  addend;
    logic              emit;
    logic              step;

    // word half: low byte as is, high byte shifted into the upper half
    assign addend = r_high_next ? {r_in_byte, {BYTE_W{1'b0}}}
                                : {{BYTE_W{1'b0}}, r_in_byte};
    assign n_first = fold_add(r_first, addend);
    // second sum moves only once a word is complete or the message ends
    assign n_second = (r_high_next || r_in_last) ? fold_add(r_second, n_first) : r_second;

    assign emit = r_in_last;
    assign step = r_in_valid && (!emit || i_res_ready);

    assign o_res.valid    = r_in_valid && emit;
    assign o_res.checksum = {n_second, n_first};

    assign i_byte.ready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    // running sums, back to their start values after each message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= SUM_INIT;
            r_second    <= SUM_INIT;
            r_high_next <= 1'b0;
        end else if (step) begin
            if (emit) begin
                r_first     <= SUM_INIT;
                r_second    <= SUM_INIT;
                r_high_next <= 1'b0;
            end else begin
                r_first     <= n_first;
                r_second    <= n_second;
                r_high_next <= !r_high_next;
            end
        end
    end

    // sums are never held as zero
    a_first_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first != '0) else $error("first sum held as zero");

    a_second_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second != '0) else $error("second sum held as zero");

    // a delivered checksum restarts the message state
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && emit) |=> (r_first == SUM_INIT && r_second == SUM_INIT && !r_high_next))
        else $error("state not restarted after checksum");

    // a stalled result keeps its item in the input register
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !i_res_ready) |=> (r_in_valid && r_in_last))
        else $error("stalled result lost");

endmodule

@@ design/f32_out_buf.sv @@
// ----------------------------------------------------------------------------
// f32_out_buf
// Result register between the accumulator and the checksum output channel.
// ----------------------------------------------------------------------------
module f32_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  f32_pkg::t_result i_res,
    output logic             o_res_ready,
    f32_sum_if.source        o_sum
);
    import f32_pkg::*;

    logic              r_valid;
    logic [CSUM_W-1:0] r_checksum;

    assign o_res_ready = !r_valid || o_sum.ready;

    // valid flag of the held result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res.valid) begin
            r_checksum <= i_res.checksum;
        end
    end

    assign o_sum.valid    = r_valid;
    assign o_sum.checksum = r_checksum;

    // a captured result shows on the output at the next edge
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.valid && o_res_ready) |=> (r_valid && r_checksum == $past(i_res.checksum)))
        else $error("result not captured");

    // both halves of a held checksum are nonzero
    a_halves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_checksum[SUM_W-1:0] != '0 && r_checksum[CSUM_W-1:SUM_W] != '0))
        else $error("checksum half is zero");

    // a stalled checksum stays put until its transfer
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_sum.ready) |=> (r_valid && $stable(r_checksum)))
        else $error("stalled checksum changed");

endmodule
